/* rtl/rep_pkg.sv */
`default_nettype none

package rep_pkg;

  // Width of bulk length and payload byte counters
  localparam int LEN_BITS_DEF = 32;

  localparam int QUOTA_W  = 16;
  localparam int LIMIT_W  = 32;
  localparam int DIGITS_W = 5;
  localparam int VALUE_W  = 64;

  // Configuration register indexes
  localparam logic [1:0] CFG_STRING_QUOTA = 2'd0;
  localparam logic [1:0] CFG_BULK_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_DIGIT_LIMIT  = 2'd2;

  localparam logic [QUOTA_W-1:0]  QUOTA_RST     = 16'd1024;
  localparam logic [LIMIT_W-1:0]  BULK_LIM_RST  = 32'd1048576;
  localparam logic [DIGITS_W-1:0] DIGIT_LIM_RST = 5'd20;
  localparam logic [DIGITS_W-1:0] DIGIT_LIM_MAX = 5'd20;

  // Result events
  localparam logic [1:0] EV_CONSUMED = 2'd0;
  localparam logic [1:0] EV_PAYLOAD  = 2'd1;
  localparam logic [1:0] EV_COMPLETE = 2'd2;
  localparam logic [1:0] EV_ERROR    = 2'd3;

  // Element kinds
  localparam logic [2:0] KIND_STR     = 3'd0;
  localparam logic [2:0] KIND_INT     = 3'd1;
  localparam logic [2:0] KIND_BULK    = 3'd2;
  localparam logic [2:0] KIND_ARR     = 3'd3;
  localparam logic [2:0] KIND_ERRLINE = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ERR_NONDIGIT  = 3'd2;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
  localparam logic [2:0] ERR_NO_LF     = 3'd4;
  localparam logic [2:0] ERR_QUOTA     = 3'd5;
  localparam logic [2:0] ERR_BULK_SIZE = 3'd6;
  localparam logic [2:0] ERR_BULK_END  = 3'd7;

  // Stream characters
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] DIGIT_MSK = 8'h0F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  // Parser phases, one-hot
  typedef enum logic [7:0] {
    PH_TYPE    = 8'b0000_0001,
    PH_DIG     = 8'b0000_0010,
    PH_DIG_LF  = 8'b0000_0100,
    PH_STR     = 8'b0000_1000,
    PH_STR_LF  = 8'b0001_0000,
    PH_BULK    = 8'b0010_0000,
    PH_BULK_CR = 8'b0100_0000,
    PH_BULK_LF = 8'b1000_0000
  } phase_t;

  // Live configuration seen by the parser core
  typedef struct packed {
    logic [QUOTA_W-1:0]  string_quota;
    logic [LIMIT_W-1:0]  bulk_limit;
    logic [DIGITS_W-1:0] digit_limit;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [1:0]         event_res;
    logic [2:0]         element_kind;
    logic [7:0]         payload_byte;
    logic [VALUE_W-1:0] value;
    logic [2:0]         error_code;
  } res_t;

endpackage

`default_nettype wire

/* rtl/rep_cfg_regs.sv */
`default_nettype none

module rep_cfg_regs
  import rep_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output cfg_t             cfg
);

  logic [QUOTA_W-1:0]  quota_r;
  logic [LIMIT_W-1:0]  bulk_lim_r;
  logic [DIGITS_W-1:0] digit_lim_r;
  logic [DIGITS_W-1:0] digit_clamped;

  assign cfg_ready = 1'b1;

  // Low five bits of cfg_data above twenty act as twenty; clamp once at write time
  assign digit_clamped = (cfg_data[DIGITS_W-1:0] > DIGIT_LIM_MAX) ? DIGIT_LIM_MAX
                                                                  : cfg_data[DIGITS_W-1:0];

  // Register file write; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quota_r     <= QUOTA_RST;
      bulk_lim_r  <= BULK_LIM_RST;
      digit_lim_r <= DIGIT_LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STRING_QUOTA: quota_r     <= cfg_data[QUOTA_W-1:0];
        CFG_BULK_LIMIT:   bulk_lim_r  <= cfg_data[LIMIT_W-1:0];
        CFG_DIGIT_LIMIT:  digit_lim_r <= digit_clamped;
        default: ;
      endcase
    end
  end

  assign cfg.string_quota = quota_r;
  assign cfg.bulk_limit   = bulk_lim_r;
  assign cfg.digit_limit  = digit_lim_r;

endmodule

`default_nettype wire

/* rtl/rep_core.sv */
`default_nettype none

module rep_core
  import rep_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] step_byte,
  input  wire cfg_t       cfg,
  output res_t            res
);

  phase_t              phase_r, phase_nxt;
  logic [2:0]          kind_r, kind_nxt;
  logic [VALUE_W-1:0]  acc_r, acc_nxt;
  logic [DIGITS_W-1:0] dcnt_r, dcnt_nxt;
  logic [LEN_BITS-1:0] bcnt_r, bcnt_nxt;
  logic [LEN_BITS-1:0] blen_r, blen_nxt;

  logic [VALUE_W+3:0]  acc_x10;
  logic [LEN_BITS-1:0] bcnt_inc;
  logic                is_digit;
  logic                too_wide;

  // acc*10 + digit, four guard bits catch 64-bit overflow
  assign acc_x10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                 + {(VALUE_W + 4 - 4)'(0), 4'(step_byte & DIGIT_MSK)};
  assign bcnt_inc = bcnt_r + 1'b1;
  assign is_digit = (step_byte >= CH_ZERO) && (step_byte <= CH_NINE);

  // Declared bulk length must fit the length counters
  generate
    if (LEN_BITS < VALUE_W) begin : g_narrow
      assign too_wide = |acc_r[VALUE_W-1:LEN_BITS];
    end else begin : g_full
      assign too_wide = 1'b0;
    end
  endgenerate

  // Per-byte next state and result
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    acc_nxt   = acc_r;
    dcnt_nxt  = dcnt_r;
    bcnt_nxt  = bcnt_r;
    blen_nxt  = blen_r;
    res.event_res    = EV_CONSUMED;
    res.payload_byte = 8'd0;
    res.value        = '0;
    res.error_code   = ERR_NONE;

    unique case (phase_r)
      PH_TYPE: begin
        acc_nxt  = '0;
        dcnt_nxt = '0;
        bcnt_nxt = '0;
        blen_nxt = '0;
        case (step_byte)
          CH_PLUS:   begin kind_nxt = KIND_STR;     phase_nxt = PH_STR; end
          CH_MINUS:  begin kind_nxt = KIND_ERRLINE; phase_nxt = PH_STR; end
          CH_COLON:  begin kind_nxt = KIND_INT;     phase_nxt = PH_DIG; end
          CH_DOLLAR: begin kind_nxt = KIND_BULK;    phase_nxt = PH_DIG; end
          CH_STAR:   begin kind_nxt = KIND_ARR;     phase_nxt = PH_DIG; end
          default: begin
            kind_nxt       = KIND_STR;
            res.event_res  = EV_ERROR;
            res.error_code = ERR_BAD_TYPE;
          end
        endcase
      end

      PH_DIG: begin
        if (step_byte == CH_CR) begin
          phase_nxt = PH_DIG_LF;
        end else if (!is_digit) begin
          res.event_res  = EV_ERROR;
          res.error_code = ERR_NONDIGIT;
        end else if (dcnt_r >= cfg.digit_limit || (|acc_x10[VALUE_W+3:VALUE_W])) begin
          res.event_res  = EV_ERROR;
          res.error_code = ERR_TOO_LONG;
        end else begin
          acc_nxt  = acc_x10[VALUE_W-1:0];
          dcnt_nxt = dcnt_r + 1'b1;
        end
      end

      PH_DIG_LF: begin
        if (step_byte != CH_LF) begin
          res.event_res  = EV_ERROR;
          res.error_code = ERR_NO_LF;
        end else if (kind_r != KIND_BULK) begin
          res.event_res = EV_COMPLETE;
          res.value     = acc_r;
        end else if (acc_r > VALUE_W'(cfg.bulk_limit) || too_wide) begin
          res.event_res  = EV_ERROR;
          res.error_code = ERR_BULK_SIZE;
        end else begin
          blen_nxt  = acc_r[LEN_BITS-1:0];
          bcnt_nxt  = '0;
          phase_nxt = (acc_r == '0) ? PH_BULK_CR : PH_BULK;
        end
      end

      PH_STR: begin
        if (step_byte == CH_CR) begin
          phase_nxt = PH_STR_LF;
        end else if (VALUE_W'(bcnt_r) >= VALUE_W'(cfg.string_quota)) begin
          res.event_res  = EV_ERROR;
          res.error_code = ERR_QUOTA;
        end else begin
          bcnt_nxt         = bcnt_inc;
          res.event_res    = EV_PAYLOAD;
          res.payload_byte = step_byte;
        end
      end

      PH_STR_LF: begin
        if (step_byte != CH_LF) begin
          res.event_res  = EV_ERROR;
          res.error_code = ERR_NO_LF;
        end else begin
          res.event_res = EV_COMPLETE;
          res.value     = VALUE_W'(bcnt_r);
        end
      end

      PH_BULK: begin
        bcnt_nxt         = bcnt_inc;
        res.event_res    = EV_PAYLOAD;
        res.payload_byte = step_byte;
        if (bcnt_inc >= blen_r) phase_nxt = PH_BULK_CR;
      end

      PH_BULK_CR: begin
        if (step_byte != CH_CR) begin
          res.event_res  = EV_ERROR;
          res.error_code = ERR_BULK_END;
        end else begin
          phase_nxt = PH_BULK_LF;
        end
      end

      PH_BULK_LF: begin
        if (step_byte != CH_LF) begin
          res.event_res  = EV_ERROR;
          res.error_code = ERR_BULK_END;
        end else begin
          res.event_res = EV_COMPLETE;
          res.value     = VALUE_W'(blen_r);
        end
      end

      default: phase_nxt = PH_TYPE;
    endcase

    // Errors and completions return to the type byte
    if (res.event_res == EV_ERROR || res.event_res == EV_COMPLETE) phase_nxt = PH_TYPE;
    res.element_kind = kind_nxt;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      kind_r  <= KIND_STR;
      acc_r   <= '0;
      dcnt_r  <= '0;
      bcnt_r  <= '0;
      blen_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      acc_r   <= acc_nxt;
      dcnt_r  <= dcnt_nxt;
      bcnt_r  <= bcnt_nxt;
      blen_r  <= blen_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_to_type: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (res.event_res == EV_ERROR || res.event_res == EV_COMPLETE)
    |=> phase_r == PH_TYPE)
    else $error("parser did not return to type byte after element end");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= DIGIT_LIM_MAX)
    else $error("digit count beyond twenty");

  a_bulk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BULK) |-> (bcnt_r < blen_r))
    else $error("bulk payload count past declared length");
`endif

endmodule

`default_nettype wire

/* rtl/resp_element_parser.sv */
// Channel  Dir  Handshake         Payload
// in_      in   in_valid/in_stall   in_byte (one stream byte)
// out_     out  out_valid/out_stall event, kind, payload byte, value, error code
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data (register write)
//
// One byte a cycle sustained while out_stall stays low; each byte's result passes
// through the input register, then the parser state update into the result register,
// from which it can transfer out.
// The 64-bit times-ten accumulate and compare sets the parser stage path.
// rst_n is synchronous: parser returns to awaiting a type byte, registers reload.
// in_stall rises only while the input stage holds a byte and the result is stalled.
`default_nettype none

module resp_element_parser
  import rep_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_event_res,
  output logic [2:0]       out_element_kind,
  output logic [7:0]       out_payload_byte,
  output logic [63:0]      out_value,
  output logic [2:0]       out_error_code,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t       cfg;
  res_t       res;
  res_t       res_r;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  logic       proc_stall;
  logic       proc_en;

  rep_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake between stages
  assign proc_stall = out_valid_r && out_stall;
  assign proc_en    = in_valid_r && !proc_stall;
  assign in_stall   = in_valid_r && proc_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (proc_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_byte_r <= in_byte;
  end

  rep_core #(
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (proc_en),
    .step_byte (in_byte_r),
    .cfg       (cfg),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_en) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en) res_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = res_r.event_res;
  assign out_element_kind = res_r.element_kind;
  assign out_payload_byte = res_r.payload_byte;
  assign out_value        = res_r.value;
  assign out_error_code   = res_r.error_code;

`ifndef NO_ASSERTIONS
  a_proc_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    proc_en |=> out_valid_r)
    else $error("processed byte did not reach result register");

  a_err_code_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_event_res == EV_ERROR) == (out_error_code != ERR_NONE)))
    else $error("error code disagrees with event");

  a_payload_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_res != EV_COMPLETE |-> out_value == '0)
    else $error("value set outside completion");

  a_no_double_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && in_valid_r)
    else $error("input stalled without a pending result");
`endif

endmodule

`default_nettype wire
